// File: design/m3inv_pkg.sv
// m3inv_pkg: shared widths, queue entry type and cofactor index map
// for the 3x3 matrix inverse unit; no dependencies
`timescale 1ns / 1ps
package m3inv_pkg;
    localparam int ELEM_W = 32;
    localparam int PROD_W = 64;
    localparam int COF_W  = 65;
    localparam int DET_W  = 98;
    localparam int DMAG_W = 97;
    localparam int CMAG_W = 64;
    localparam int Q_W    = 33;
    localparam int QDEPTH = 8;
    localparam int QIDX_W = 3;
    localparam int QCNT_W = 4;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;

    typedef struct packed {
        logic [8:0][COF_W-1:0] cof;
        logic [DET_W-1:0]      det;
    } t_qent;

    // element indices (row-major) of cofactor k = m[a]*m[b] - m[c]*m[d]
    function automatic logic [15:0] cf_idx(input logic [3:0] k);
        logic [15:0] v;
        unique case (k)
            4'd0:    v = {4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    v = {4'd7, 4'd2, 4'd8, 4'd1};
            4'd2:    v = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    v = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    v = {4'd8, 4'd0, 4'd6, 4'd2};
            4'd5:    v = {4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    v = {4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    v = {4'd6, 4'd1, 4'd7, 4'd0};
            4'd8:    v = {4'd0, 4'd4, 4'd1, 4'd3};
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// File: design/m3inv_front.sv
// m3inv_front: five-stage pipeline forming the nine cofactors and the
// determinant of each accepted matrix; uses m3inv_pkg
`timescale 1ns / 1ps
module m3inv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  m3inv_pkg::t_elem      i_m [9],
    output logic                  o_valid,
    output m3inv_pkg::t_qent      o_ent,
    output logic [2:0]            o_busy
);
    import m3inv_pkg::*;

    logic [5:1] r_v;
    logic signed [PROD_W-1:0] r_p [18];
    t_elem r_row1 [3], r_row2 [3], r_row3 [3];
    t_cof  r_cof2 [9], r_cof3 [9], r_cof4 [9];
    logic signed [65:0] r_lo [3];
    logic signed [63:0] r_hi [3];
    t_det  r_prod [3];
    t_qent r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] ix;
        for (int k = 0; k < 9; k++) begin
            ix = cf_idx(4'(k));
            r_p[2*k]   <= i_m[ix[15:12]] * i_m[ix[11:8]];
            r_p[2*k+1] <= i_m[ix[7:4]] * i_m[ix[3:0]];
        end
        for (int j = 0; j < 3; j++) begin
            r_row1[j] <= i_m[j];
            r_row2[j] <= r_row1[j];
        end
        for (int k = 0; k < 9; k++) begin
            r_cof2[k] <= t_cof'(r_p[2*k]) - t_cof'(r_p[2*k+1]);
            r_cof3[k] <= r_cof2[k];
            r_cof4[k] <= r_cof3[k];
        end
        // row-0 element times cofactor, split into two narrow products
        for (int j = 0; j < 3; j++) begin
            r_lo[j] <= r_row2[j] * $signed({1'b0, r_cof2[3*j][32:0]});
            r_hi[j] <= r_row2[j] * $signed(r_cof2[3*j][64:33]);
            r_prod[j] <= ({{34{r_hi[j][63]}}, r_hi[j]} <<< 33)
                       + {{32{r_lo[j][65]}}, r_lo[j]};
        end
        r_ent.det <= r_prod[0] + r_prod[1] + r_prod[2];
        for (int k = 0; k < 9; k++) begin
            r_ent.cof[k] <= r_cof4[k];
        end
    end

    assign o_valid = r_v[5];
    assign o_ent   = r_ent;
    assign o_busy  = 3'(r_v[1]) + 3'(r_v[2]) + 3'(r_v[3]) + 3'(r_v[4]) + 3'(r_v[5]);
endmodule

// File: design/m3inv_queue.sv
// m3inv_queue: eight-entry queue between front pipeline and divider back end
// uses m3inv_pkg
`timescale 1ns / 1ps
module m3inv_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  m3inv_pkg::t_qent           i_ent,
    input  logic                       i_pop,
    output logic                       o_empty,
    output m3inv_pkg::t_qent           o_ent,
    output logic [m3inv_pkg::QCNT_W-1:0] o_cnt
);
    import m3inv_pkg::*;

    t_qent r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rd];
    assign o_cnt   = r_cnt;

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH)) else $error("queue overflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == QCNT_W'(QDEPTH)) |-> !i_push) else $error("push into full queue");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd)) else $error("pointer mismatch");
endmodule

// File: design/m3inv_back.sv
// m3inv_back: shared restoring divider forming the nine rounded, saturated
// quotients (zeros for a singular matrix), plus the output register; uses m3inv_pkg
`timescale 1ns / 1ps
module m3inv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  m3inv_pkg::t_qent     i_ent,
    output logic                 o_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic signed [31:0]   o_inv [9],
    output logic                 o_singular
);
    import m3inv_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_st;
    logic [3:0] r_k;
    logic [5:0] r_cnt;
    logic [8:0][COF_W-1:0] r_cof;
    logic [DMAG_W-1:0] r_d;
    logic [DET_W-1:0]  r_r;
    logic [Q_W-1:0]    r_q;
    logic r_neg, r_sat, r_sing, r_ovalid, r_det_neg;
    logic [31:0] r_res [9];

    logic [COF_W-1:0]  cur;
    logic [CMAG_W-1:0] cmag;
    logic [DMAG_W-1:0] dmag;
    logic [DET_W-1:0]  rs;
    logic              ge;
    logic [Q_W:0]      qr;
    logic [31:0]       val;
    logic              out_free;

    assign out_free = !r_ovalid || i_pop;
    assign cur  = r_cof[r_k];
    assign cmag = cur[COF_W-1] ? CMAG_W'(-cur) : cur[CMAG_W-1:0];
    assign dmag = i_ent.det[DET_W-1] ? DMAG_W'(-i_ent.det) : i_ent.det[DMAG_W-1:0];
    assign rs   = (r_cnt == 6'd32) ? r_r : {r_r[DET_W-2:0], 1'b0};
    assign ge   = rs >= {1'b0, r_d};
    assign qr   = {1'b0, r_q} + (Q_W+1)'({r_r, 1'b0} >= {2'b0, r_d});

    always_comb begin
        if (r_sat) begin
            val = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (!r_neg) begin
            val = (qr > (Q_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qr[31:0];
        end else begin
            val = (qr > (Q_W+1)'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-qr[31:0]);
        end
    end

    assign o_take = (r_st == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cof     <= i_ent.cof;
                        r_d       <= dmag;
                        r_det_neg <= i_ent.det[DET_W-1];
                        r_k       <= '0;
                        if (i_ent.det == '0) begin
                            r_sing <= 1'b1;
                            for (int k = 0; k < 9; k++) r_res[k] <= '0;
                            r_st <= S_DONE;
                        end else begin
                            r_sing <= 1'b0;
                            r_st   <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_neg <= cur[COF_W-1] ^ r_det_neg;
                    // quotient at or above 2^33 saturates either way
                    r_sat <= {1'b0, cmag} >= {r_d, 1'b0};
                    r_r   <= DET_W'(cmag);
                    r_q   <= '0;
                    r_cnt <= 6'd32;
                    r_st  <= S_STEP;
                end
                S_STEP: begin
                    r_r   <= ge ? rs - {1'b0, r_d} : rs;
                    r_q   <= {r_q[Q_W-2:0], ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_st <= S_FIN;
                end
                S_FIN: begin
                    r_res[r_k] <= val;
                    if (r_k == 4'd8) begin
                        r_st <= S_DONE;
                    end else begin
                        r_k  <= r_k + 1'b1;
                        r_st <= S_INIT;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        for (int k = 0; k < 9; k++) o_inv[k] <= r_res[k];
                        o_singular <= r_sing;
                        r_st       <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_empty = !r_ovalid;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_singular) |-> (o_inv[0] == '0 && o_inv[4] == '0 && o_inv[8] == '0))
        else $error("singular result not zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_pop) |=> (r_ovalid && $stable(o_inv[0]) && $stable(o_singular)))
        else $error("result changed before transfer");
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FIN && !r_sat) |-> (r_r < {1'b0, r_d}))
        else $error("remainder not below divisor");
    a_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> (r_k <= 4'd8)) else $error("element index out of range");
endmodule

// File: design/matrix3_inverse_unit.sv
// matrix3_inverse_unit: 3x3 Q16.16 matrix inverse by adjugate and determinant
// the shared one-bit-per-cycle divider takes one matrix at a time, element by
// element; a singular matrix skips the division steps and goes to the output
// register
// front accepts up to 8 matrices ahead of the divider
// reset: synchronous active-low i_rst_n empties the pipeline, queue and output
`timescale 1ns / 1ps
module matrix3_inverse_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  i_m00, i_m01, i_m02,
    input  logic signed [31:0]  i_m10, i_m11, i_m12,
    input  logic signed [31:0]  i_m20, i_m21, i_m22,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_inv00, o_inv01, o_inv02,
    output logic signed [31:0]  o_inv10, o_inv11, o_inv12,
    output logic signed [31:0]  o_inv20, o_inv21, o_inv22,
    output logic                o_singular
);
    import m3inv_pkg::*;

    t_elem m [9];
    logic  in_xfer, f_valid, q_empty, take;
    t_qent f_ent, q_ent;
    logic [2:0] busy;
    logic [QCNT_W-1:0] q_cnt;
    logic signed [31:0] inv [9];

    assign m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};
    // reserve queue room for every matrix still in the front pipeline
    assign full    = (5'(q_cnt) + 5'(busy)) >= 5'(QDEPTH);
    assign in_xfer = push && !full;

    m3inv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_xfer), .i_m(m),
        .o_valid(f_valid), .o_ent(f_ent), .o_busy(busy)
    );

    m3inv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid), .i_ent(f_ent),
        .i_pop(take), .o_empty(q_empty), .o_ent(q_ent), .o_cnt(q_cnt)
    );

    m3inv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .i_ent(q_ent),
        .o_take(take), .o_empty(empty), .i_pop(pop), .o_inv(inv),
        .o_singular(o_singular)
    );

    assign o_inv00 = inv[0];
    assign o_inv01 = inv[1];
    assign o_inv02 = inv[2];
    assign o_inv10 = inv[3];
    assign o_inv11 = inv[4];
    assign o_inv12 = inv[5];
    assign o_inv20 = inv[6];
    assign o_inv21 = inv[7];
    assign o_inv22 = inv[8];
endmodule

// File: tb/tb.sv
// tb: self-checking bench for matrix3_inverse_unit, 3x3 Q16.16 inverse
// depends on design/matrix3_inverse_unit.sv; predicts each inverse at full precision
`timescale 1ns / 1ps
module tb;
    typedef struct {
        logic signed [31:0] m[9];
    } t_mat;
    typedef struct {
        logic signed [31:0] inv[9];
        logic               sing;
    } t_inv;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [31:0] i_m[9];
    logic signed [31:0] o_inv[9];
    logic o_singular;

    t_mat mat_q[$];
    t_inv inverse_q[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off_cycles = 0;
    int   errors = 0;
    longint cycles = 0;

    always #1 i_clk = ~i_clk;

    initial for (int k = 0; k < 9; k++) i_m[k] = '0;

    matrix3_inverse_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_m00(i_m[0]), .i_m01(i_m[1]), .i_m02(i_m[2]),
        .i_m10(i_m[3]), .i_m11(i_m[4]), .i_m12(i_m[5]),
        .i_m20(i_m[6]), .i_m21(i_m[7]), .i_m22(i_m[8]),
        .empty(empty), .pop(pop),
        .o_inv00(o_inv[0]), .o_inv01(o_inv[1]), .o_inv02(o_inv[2]),
        .o_inv10(o_inv[3]), .o_inv11(o_inv[4]), .o_inv12(o_inv[5]),
        .o_inv20(o_inv[6]), .o_inv21(o_inv[7]), .o_inv22(o_inv[8]),
        .o_singular(o_singular)
    );

    // round(cof * 2^32 / det), half away from zero, saturated to 32 bits
    function automatic logic signed [31:0] scaled_quotient(logic signed [127:0] cof,
                                                           logic signed [127:0] det);
        logic [191:0] num, den, q, r;
        logic neg;
        num = (cof < 0) ? -cof : cof;
        den = (det < 0) ? -det : det;
        neg = (cof < 0) != (det < 0);
        num = num << 32;
        q = num / den;
        r = num % den;
        if (2 * r >= den) q = q + 1;
        if (!neg) return (q > 192'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        return (q > 192'h80000000) ? 32'sh80000000 : -q[31:0];
    endfunction

    function automatic t_inv invert_matrix(t_mat a);
        t_inv res;
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic signed [127:0] e[9];
        for (int k = 0; k < 9; k++) e[k] = a.m[k];
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[7]*e[2] - e[8]*e[1];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[8]*e[0] - e[6]*e[2];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[6]*e[1] - e[7]*e[0];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        res.sing = (det == 0);
        for (int k = 0; k < 9; k++)
            res.inv[k] = res.sing ? 32'sd0 : scaled_quotient(adj[k], det);
        return res;
    endfunction

    function automatic t_mat cur_from_ports();
        t_mat c;
        for (int k = 0; k < 9; k++) c.m[k] = i_m[k];
        return c;
    endfunction

    // driver: push stays high across back-to-back transfers while send_idle_pct is zero
    always @(posedge i_clk) begin
        t_mat cur;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (push && !full) begin
                inverse_q.push_back(invert_matrix(cur_from_ports()));
                void'(mat_q.pop_front());
            end
            if (mat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur = mat_q[0];
                for (int k = 0; k < 9; k++) i_m[k] <= cur.m[k];
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: check each result transfer, then choose next pop
    always @(posedge i_clk) begin
        t_inv want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (inverse_q.size() == 0) begin
                    $error("result with no matrix outstanding");
                    errors++;
                end else begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (o_inv[k] !== want.inv[k]) begin
                            $error("inv%0d%0d: expected %0d actual %0d", k / 3, k % 3,
                                   want.inv[k], o_inv[k]);
                            errors++;
                        end
                    if (o_singular !== want.sing) begin
                        $error("singular: expected %0d actual %0d", want.sing, o_singular);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
            2: return $signed($urandom_range(512)) - 256;
            3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(65536 * 64)) - 65536 * 32;
        endcase
    endfunction

    task automatic add_matrix(input logic signed [31:0] a0, a1, a2, a3, a4, a5, a6, a7,
                              a8);
        t_mat t;
        t.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        mat_q.push_back(t);
    endtask

    task automatic add_random(input int count);
        t_mat t;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 9; k++) t.m[k] = rand_elem();
            // make some rows dependent so singular cases appear
            if ($urandom_range(9) == 0) for (int k = 0; k < 3; k++) t.m[6 + k] = t.m[k];
            // near-identity scaled diagonals keep results in range
            if ($urandom_range(3) == 0)
                for (int k = 0; k < 9; k++)
                    t.m[k] = (k % 4 == 0) ? $signed($urandom_range(65536 * 8)) + 1024
                                           : $signed($urandom_range(8192)) - 4096;
            mat_q.push_back(t);
        end
    endtask

    task automatic wait_drained();
        while (mat_q.size() > 0 || push || inverse_q.size() > 0) @(posedge i_clk);
    endtask

    localparam logic signed [31:0] ONE = 32'sh00010000;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: identity, zero, extremes, saturation, rounding, singular
        add_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        add_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV);
        add_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV);
        add_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_matrix(-1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_matrix(3, 0, 0, 0, 3, 0, 0, 0, 3);
        add_matrix(32'sh00020000, 0, 0, 0, 32'sh00030000, 0, 0, 0, -32'sh00070000);
        add_matrix(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV);
        add_matrix(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        add_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE,
                   9 * ONE);
        add_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
        add_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        add_matrix(2, 1, 0, 1, 2, 1, 0, 1, 2);
        add_matrix(MAXV, 1, 0, 0, 1, 0, 0, 0, MINV);
        wait_drained();
        send_idle_pct = 63; recv_stall_pct = 0;
        add_random(380);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 63;
        add_random(380);
        wait_drained();
        send_idle_pct = 23; recv_stall_pct = 23;
        add_random(380);
        wait_drained();
        // long hold-off while pushing without gaps, so the front fills and stalls
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_cycles = 6000;
        add_random(395);
        wait_drained();
        repeat (700) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end
endmodule
